[rtl/core/iira_pkg.sv]
// ----------------------------------------------------------------------------
// iira_pkg: shared types and constants for the indexed insert/remove array
// Opcodes, status codes, port field widths, controller states and the
// command bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package iira_pkg;

  // Port field widths (fixed by the interface)
  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  // Default storage geometry
  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Opcodes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_READ      = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_REMOVE    = 3'd4
  } op_e;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic commit;  // execute the held operation and load the result
  } iira_cmd_t;

endpackage

[rtl/core/iira_ctrl.sv]
// ----------------------------------------------------------------------------
// iira_ctrl: transaction controller
// Takes one operation at a time, waits for the result register to be free,
// then tells the datapath to execute and tracks the output valid.
// ----------------------------------------------------------------------------
module iira_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output iira_pkg::iira_cmd_t cmd_o
);
  import iira_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       res_free;

  // Result slot is free when empty or being drained this cycle
  assign res_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (res_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = res_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/iira_dpath.sv]
// ----------------------------------------------------------------------------
// iira_dpath: entry cells, count and result register
// A row of cells, each of which loads its neighbor, the new value or holds,
// so an insert or remove shifts the whole tail in one commit.
// ----------------------------------------------------------------------------
module iira_dpath #(
  parameter int unsigned CAPACITY    = iira_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = iira_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iira_pkg::iira_cmd_t         cmd_i,
  input  logic [iira_pkg::OP_W-1:0]   opcode_i,
  input  logic [iira_pkg::IDX_W-1:0]  index_i,
  input  logic [iira_pkg::DATA_W-1:0] value_i,
  output logic [iira_pkg::STAT_W-1:0] status_o,
  output logic [iira_pkg::DATA_W-1:0] read_data_o,
  output logic [iira_pkg::CNT_W-1:0]  count_o,
  output logic                        is_empty_o
);
  import iira_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  // Held operation
  logic [OP_W-1:0]        op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // State
  logic [VALUE_WIDTH-1:0] entries_q [CAPACITY];
  logic [CW-1:0]          count_q, count_d;

  // Result register
  logic [STAT_W-1:0]      status_q, status_d;
  logic [VALUE_WIDTH-1:0] rdata_q, rdata_d;

  logic [CMPW-1:0]        idx_x, cnt_x;
  logic [VALUE_WIDTH-1:0] rd_word;
  logic                   is_full;
  logic                   do_append, do_insert, do_write, do_remove;

  assign idx_x   = CMPW'(idx_q);
  assign cnt_x   = CMPW'(count_q);
  assign is_full = (count_q == CW'(CAPACITY));
  assign rd_word = entries_q[idx_x[AW-1:0]];

  // Capture transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      idx_q <= index_i;
      val_q <= VALUE_WIDTH'(value_i);
    end
  end

  // Operation decode and range checks
  always_comb begin
    status_d  = ST_OK;
    rdata_d   = '0;
    count_d   = count_q;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_write  = 1'b0;
    do_remove = 1'b0;
    unique case (op_q)
      OP_APPEND: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (idx_x > cnt_x) begin
          status_d = ST_RANGE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_READ: begin
        if (idx_x >= cnt_x) status_d = ST_RANGE;
        else                rdata_d  = rd_word;
      end
      OP_OVERWRITE: begin
        if (idx_x >= cnt_x) status_d = ST_RANGE;
        else                do_write = 1'b1;
      end
      OP_REMOVE: begin
        if (idx_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          rdata_d   = rd_word;
          do_remove = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMPW-1:0] POS  = CMPW'(i);
    localparam logic [CMPW-1:0] POS1 = CMPW'(i + 1);
    logic [VALUE_WIDTH-1:0] left_w, right_w;
    logic                   ld_val, ld_left, ld_right;

    if (i > 0) begin : g_left
      assign left_w = entries_q[i-1];
    end else begin : g_nleft
      assign left_w = '0;
    end

    if (i < CAPACITY - 1) begin : g_right
      assign right_w = entries_q[i+1];
    end else begin : g_nright
      assign right_w = '0;
    end

    assign ld_val   = cmd_i.commit && (((do_insert || do_write) && (POS == idx_x)) ||
                                       (do_append && (POS == cnt_x)));
    assign ld_left  = cmd_i.commit && do_insert && (POS > idx_x) && (POS <= cnt_x);
    assign ld_right = cmd_i.commit && do_remove && (POS >= idx_x) && (POS1 < cnt_x);

    always_ff @(posedge clk_i) begin
      if (ld_val) begin
        entries_q[i] <= val_q;
      end else if (ld_left) begin
        entries_q[i] <= left_w;
      end else if (ld_right) begin
        entries_q[i] <= right_w;
      end
    end
  end

  // Count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
    end
  end

  // count_q only moves on commit, so it holds with the result
  assign status_o    = status_q;
  assign read_data_o = DATA_W'(rdata_q);
  assign count_o     = CNT_W'(count_q);
  assign is_empty_o  = (count_q == '0);

endmodule

[rtl/core/indexed_insert_remove_array.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_array: ordered word store with indexed insert/remove
// Append, insert, read, overwrite and remove on up to CAPACITY words; every
// result reports status, data, count and an empty flag.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o | opcode_i, index_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, read_data_o,
//           |           |                         | count_o, is_empty_o
//
// Each transaction is captured in S_IDLE, then executed in S_EXEC on the cell
// row (the whole tail shifts on that commit), which also loads the result.
// A new transaction is not taken until the last one has executed.
// Reset clears the count and the control state; entry contents are undefined.
// A new transaction is taken while a result waits; execution holds until the
// result register is drained.
//
module indexed_insert_remove_array #(
  parameter int unsigned CAPACITY    = iira_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = iira_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [iira_pkg::OP_W-1:0]   opcode_i,
  input  logic [iira_pkg::IDX_W-1:0]  index_i,
  input  logic [iira_pkg::DATA_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [iira_pkg::STAT_W-1:0] status_o,
  output logic [iira_pkg::DATA_W-1:0] read_data_o,
  output logic [iira_pkg::CNT_W-1:0]  count_o,
  output logic                        is_empty_o
);
  import iira_pkg::*;

  iira_cmd_t cmd;

  // Controller
  iira_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath
  iira_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (opcode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  // One transaction in flight: after a capture, input is held off
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while one is executing");

  // Execution always produces a visible result
  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("result not presented after execution");

  // Execution never overwrites a result still waiting on a stall
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // Failed operations return no data
  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (read_data_o == '0))
    else $error("data returned with error status");

endmodule
